FILE: design/mlqs_pkg.sv
// Package of the multilevel queue scheduler: constants, item types and the
// control structure passed from the front end to the dispatch engine. No dependencies.
`default_nettype none
package mlqs_pkg;
  localparam int LEVELS = 3;
  localparam int MAX_TASKS_DEF = 16;
  localparam int WORK_BITS_DEF = 12;
  localparam int SLICE_BITS_DEF = 8;
  localparam int PRIO_LEVEL0_MAX = 2;
  localparam int PRIO_LEVEL1_MAX = 4;
  localparam int ID_BITS = 4;
  localparam int PRIO_BITS = 4;
  localparam int BURST_BITS = 12;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 8;
  localparam int IN_DATA_BITS = 24;
  localparam int OUT_DATA_BITS = 8;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SLICE0 = 3'd0,
    REG_SLICE1 = 3'd1,
    REG_SLICE2 = 3'd2,
    REG_RANK0  = 3'd3,
    REG_RANK1  = 3'd4,
    REG_RANK2  = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    OP_ARRIVE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [1:0]            level;
    logic [ID_BITS-1:0]    task_id;
    logic [BURST_BITS-1:0] burst;
  } cmd_t;

  function automatic logic [1:0] prio_to_level(input logic [PRIO_BITS-1:0] prio);
    logic [1:0] lvl;
    if (prio <= PRIO_BITS'(PRIO_LEVEL0_MAX)) lvl = 2'd0;
    else if (prio <= PRIO_BITS'(PRIO_LEVEL1_MAX)) lvl = 2'd1;
    else lvl = 2'd2;
    return lvl;
  endfunction
endpackage
`default_nettype wire

FILE: design/mlqs_front.sv
// Front end of the multilevel queue scheduler: accepts input transactions,
// classifies arrivals into levels and queues commands in a short FIFO. Uses mlqs_pkg.
`default_nettype none
module mlqs_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [mlqs_pkg::IN_DATA_BITS-1:0] in_tdata,
  input  wire logic          in_tuser,
  output logic               cmd_valid,
  input  wire logic          cmd_ready,
  output mlqs_pkg::cmd_t     cmd
);
  import mlqs_pkg::*;

  localparam int QD = 2;
  cmd_t       q_r [QD];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       c_in;
  logic       push, pop;

  always_comb begin
    c_in.op      = op_t'(in_tuser);
    c_in.task_id = in_tdata[ID_BITS-1:0];
    c_in.level   = prio_to_level(in_tdata[ID_BITS +: PRIO_BITS]);
    c_in.burst   = in_tdata[ID_BITS+PRIO_BITS +: BURST_BITS];
  end

  assign in_tready = (cnt_r != 2'(QD));
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= c_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

FILE: design/mlqs_engine.sv
// Dispatch engine of the multilevel queue scheduler: level FIFOs in memory,
// task state, preemption and dispatch sequencer, output register. Uses mlqs_pkg.
`default_nettype none
module mlqs_engine #(
  parameter int MAX_TASKS  = mlqs_pkg::MAX_TASKS_DEF,
  parameter int WORK_BITS  = mlqs_pkg::WORK_BITS_DEF,
  parameter int SLICE_BITS = mlqs_pkg::SLICE_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire mlqs_pkg::cmd_t cmd,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [mlqs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [mlqs_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [mlqs_pkg::OUT_DATA_BITS-1:0] out_tdata,
  output logic                out_tuser
);
  import mlqs_pkg::*;

  localparam int PW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int SW = $clog2(LEVELS * MAX_TASKS);
  localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CMPW = ((SLICE_BITS > 8) ? SLICE_BITS : 8) + 1;
  localparam logic [SLICE_BITS-1:0] SLICE_MAX = '1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PRE  = 5'b00010,
    S_SEL  = 5'b00100,
    S_RUN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r;
  logic [7:0] slice_r [LEVELS];
  logic [1:0] rank_r  [LEVELS];
  logic [PW-1:0] head_r [LEVELS];
  logic [PW-1:0] tail_r [LEVELS];
  logic [CW-1:0] cnt_r  [LEVELS];
  logic [ID_BITS-1:0] slot_mem [LEVELS*MAX_TASKS];
  logic [WORK_BITS-1:0] work_mem [MAX_TASKS];
  logic [MAX_TASKS-1:0] disp_r;
  logic [TW-1:0]   cur_r;
  logic            curv_r;
  logic [1:0]      curl_r;
  logic [SLICE_BITS-1:0] used_r;
  logic [ID_BITS-1:0] slot_rd_r;
  logic [WORK_BITS-1:0] work_rd_r;
  logic            pop_wait_r;
  logic            ov_r;
  logic [OUT_DATA_BITS-1:0] od_r;
  logic            ou_r;

  function automatic logic ranks_ahead(input logic [1:0] a, input logic [1:0] b,
                                       input logic [1:0] ra, input logic [1:0] rb);
    logic r;
    if (ra != rb) r = ra < rb;
    else r = a < b;
    return r;
  endfunction

  logic [1:0] best;
  logic       any;
  logic       hi_pend;
  logic       slice_over;
  logic [CMPW-1:0] slc;
  logic [TW-1:0] arr_id;
  logic       out_free;
  logic       ov_load;

  always_comb begin
    best = 2'd0; any = 1'b0; hi_pend = 1'b0;
    for (int l = 0; l < LEVELS; l++) begin
      if (cnt_r[l] != '0) begin
        if (!any || ranks_ahead(2'(l), best, rank_r[l], rank_r[best])) best = 2'(l);
        any = 1'b1;
        if (ranks_ahead(2'(l), curl_r, rank_r[l], rank_r[curl_r])) hi_pend = 1'b1;
      end
    end
    slc = CMPW'(slice_r[curl_r]);
    slice_over = (slc != '0) && (CMPW'(used_r) >= slc);
  end

  assign arr_id    = TW'(cmd.task_id);
  assign cfg_ready = (state_r == S_IDLE);
  assign cmd_ready = (state_r == S_IDLE) && !cfg_valid;
  assign out_free  = !ov_r || out_tready;
  assign ov_load   = out_free && ((state_r == S_OUT) || (state_r == S_SEL && !any));

  logic req_ok;
  assign req_ok = cnt_r[curl_r] < CW'(MAX_TASKS);

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && cmd_valid && cmd.op == OP_ARRIVE && !cfg_valid
        && (32'(cmd.task_id) < MAX_TASKS) && cnt_r[cmd.level] < CW'(MAX_TASKS)) begin
      slot_mem[SW'(cmd.level) * SW'(MAX_TASKS) + SW'(tail_r[cmd.level])] <= cmd.task_id;
      work_mem[arr_id] <= WORK_BITS'(cmd.burst);
    end
    if (state_r == S_PRE && curv_r && (slice_over || hi_pend) && req_ok)
      slot_mem[SW'(curl_r) * SW'(MAX_TASKS) + SW'(tail_r[curl_r])] <= ID_BITS'(cur_r);
    if (state_r == S_SEL)
      slot_rd_r <= slot_mem[SW'(best) * SW'(MAX_TASKS) + SW'(head_r[best])];
    if (state_r == S_RUN && pop_wait_r == 1'b0)
      work_rd_r <= work_mem[cur_r];
    if (state_r == S_OUT)
      work_mem[cur_r] <= (work_rd_r <= WORK_BITS'(1)) ? '0 : work_rd_r - WORK_BITS'(1);
  end

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (32'(p) + 1 >= MAX_TASKS) r = '0;
    else r = p + PW'(1);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slice_r[0] <= 8'd2; slice_r[1] <= 8'd4; slice_r[2] <= 8'd0;
      rank_r[0] <= 2'd0; rank_r[1] <= 2'd1; rank_r[2] <= 2'd2;
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= '0; tail_r[l] <= '0; cnt_r[l] <= '0;
      end
      disp_r <= '0; cur_r <= '0; curv_r <= 1'b0; curl_r <= 2'd0; used_r <= '0;
      pop_wait_r <= 1'b0; ov_r <= 1'b0; od_r <= '0; ou_r <= 1'b0;
    end else begin
      if (ov_r && out_tready && !ov_load) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            unique case (cfg_index)
              REG_SLICE0: slice_r[0] <= cfg_data;
              REG_SLICE1: slice_r[1] <= cfg_data;
              REG_SLICE2: slice_r[2] <= cfg_data;
              REG_RANK0:  rank_r[0]  <= cfg_data[1:0];
              REG_RANK1:  rank_r[1]  <= cfg_data[1:0];
              REG_RANK2:  rank_r[2]  <= cfg_data[1:0];
              default: ;
            endcase
          end else if (cmd_valid) begin
            if (cmd.op == OP_ARRIVE) begin
              if ((32'(cmd.task_id) < MAX_TASKS) && cnt_r[cmd.level] < CW'(MAX_TASKS)) begin
                tail_r[cmd.level] <= inc(tail_r[cmd.level]);
                cnt_r[cmd.level]  <= cnt_r[cmd.level] + CW'(1);
                disp_r[arr_id]    <= 1'b0;
              end
            end else begin
              state_r <= S_PRE;
            end
          end
        end
        S_PRE: begin
          if (curv_r && (slice_over || hi_pend) && req_ok) begin
            tail_r[curl_r] <= inc(tail_r[curl_r]);
            cnt_r[curl_r]  <= cnt_r[curl_r] + CW'(1);
            curv_r <= 1'b0;
            state_r <= S_SEL;
          end else if (curv_r) begin
            pop_wait_r <= 1'b0;
            state_r <= S_RUN;
          end else begin
            state_r <= S_SEL;
          end
        end
        S_SEL: begin
          if (!any) begin
            if (out_free) begin
              ov_r <= 1'b1; od_r <= '0; ou_r <= 1'b1;
              state_r <= S_IDLE;
            end
          end else begin
            head_r[best] <= inc(head_r[best]);
            cnt_r[best]  <= cnt_r[best] - CW'(1);
            curl_r <= best; curv_r <= 1'b1; used_r <= '0;
            pop_wait_r <= 1'b1;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (pop_wait_r) begin
            cur_r <= TW'(slot_rd_r);
            pop_wait_r <= 1'b0;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            ov_r <= 1'b1; ou_r <= 1'b0;
            od_r <= {(work_rd_r <= WORK_BITS'(1)), !disp_r[cur_r], curl_r,
                     ID_BITS'(cur_r)};
            disp_r[cur_r] <= 1'b1;
            if (used_r != SLICE_MAX) used_r <= used_r + SLICE_BITS'(1);
            if (work_rd_r <= WORK_BITS'(1)) curv_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
endmodule
`default_nettype wire

FILE: design/multilevel_queue_scheduler.sv
// Top level of the multilevel queue scheduler: front end, command queue and
// dispatch engine. Depends on mlqs_pkg, mlqs_front and mlqs_engine.
//
// Channel | Direction | Contents
// in_     | input     | tdata {burst_length, task_priority, task_id}, tuser op
// out_    | output    | tdata {task_finished, first_dispatch, running_level, running_task}, tuser idle
// cfg_    | input     | register index and write data
//
// An arrival is handled in the engine's idle state. A tick passes the preempt and select
// states when it is idle; preempt, run and output when the running task goes on; and
// preempt, select, run and output when a task is taken from the level FIFO memory.
// Reset is synchronous and active low and clears all control state.
// The front queue holds two commands, so input is taken while the engine
// waits on a stalled output register.
`default_nettype none
module multilevel_queue_scheduler #(
  parameter int MAX_TASKS  = mlqs_pkg::MAX_TASKS_DEF,
  parameter int WORK_BITS  = mlqs_pkg::WORK_BITS_DEF,
  parameter int SLICE_BITS = mlqs_pkg::SLICE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // task_id [3:0], task_priority [7:4], burst_length [19:8], zeros above
  input  wire logic [mlqs_pkg::IN_DATA_BITS-1:0] in_tdata,
  // op
  input  wire logic in_tuser,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // running_task [3:0], running_level [5:4], first_dispatch [6], task_finished [7]
  output logic [mlqs_pkg::OUT_DATA_BITS-1:0] out_tdata,
  // idle
  output logic      out_tuser,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [mlqs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [mlqs_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import mlqs_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  mlqs_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .cmd_valid, .cmd_ready, .cmd
  );

  mlqs_engine #(
    .MAX_TASKS(MAX_TASKS), .WORK_BITS(WORK_BITS), .SLICE_BITS(SLICE_BITS)
  ) u_engine (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );
endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench of the multilevel queue scheduler, with a predictor
// of the three level queues. Depends on mlqs_pkg and multilevel_queue_scheduler.
// It uses a table of directed items, then random items under several register settings.
`default_nettype none
module tb_top;
  import mlqs_pkg::*;

  typedef struct packed {
    logic       idle;
    logic [3:0] run_id;
    logic [1:0] run_level;
    logic       first_run;
    logic       finished;
  } sched_result_t;

  typedef struct {
    op_t           op;
    logic [3:0]    id;
    logic [3:0]    prio;
    logic [11:0]   burst;
    bit            typed;
    sched_result_t res;
  } stim_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0, in_tuser = 0, out_tready = 0;
  logic in_tready, out_tvalid, out_tuser, cfg_ready;
  logic [IN_DATA_BITS-1:0] in_tdata = '0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic cfg_valid = 0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  bit in_typed = 0;
  sched_result_t in_typed_res = '0;

  multilevel_queue_scheduler DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Predictor state.
  logic [3:0]  lvl_fifo [LEVELS][16];
  int          fifo_head [LEVELS];
  int          fifo_tail [LEVELS];
  int          fifo_cnt [LEVELS];
  logic [11:0] work_left [16];
  bit          served [16];
  logic [3:0]  cur_id;
  logic [1:0]  cur_level;
  bit          cur_busy;
  int          slice_count;
  logic [7:0]  slice_len [LEVELS];
  logic [1:0]  level_rank [LEVELS];

  sched_result_t pending_results [$];
  int errors = 0, results_seen = 0, items_sent = 0, phases_run = 0;
  int quiet_cycles = 0;

  function automatic bit outranks(int a, int b);
    if (level_rank[a] != level_rank[b]) return level_rank[a] < level_rank[b];
    return a < b;
  endfunction

  function automatic bit queue_push(int lvl, logic [3:0] id);
    if (fifo_cnt[lvl] >= 16) return 0;
    lvl_fifo[lvl][fifo_tail[lvl]] = id;
    fifo_tail[lvl] = (fifo_tail[lvl] + 1) % 16;
    fifo_cnt[lvl]++;
    return 1;
  endfunction

  function automatic void sched_reset();
    slice_len = '{8'd2, 8'd4, 8'd0};
    level_rank = '{2'd0, 2'd1, 2'd2};
    for (int l = 0; l < LEVELS; l++) begin
      fifo_head[l] = 0;
      fifo_tail[l] = 0;
      fifo_cnt[l] = 0;
    end
    for (int i = 0; i < 16; i++) begin
      served[i] = 0;
      work_left[i] = '0;
    end
    cur_id = '0;
    cur_level = '0;
    cur_busy = 0;
    slice_count = 0;
  endfunction

  function automatic void sched_arrive(logic [3:0] id, logic [3:0] prio, logic [11:0] burst);
    int lvl;
    lvl = (prio <= 2) ? 0 : (prio <= 4) ? 1 : 2;
    if (queue_push(lvl, id)) begin
      work_left[id] = burst;
      served[id] = 0;
    end
  endfunction

  function automatic sched_result_t sched_tick();
    sched_result_t r;
    bit preempt;
    int best;
    r = '0;
    if (cur_busy) begin
      preempt = slice_len[cur_level] != 0 && slice_count >= slice_len[cur_level];
      for (int l = 0; l < LEVELS; l++)
        if (fifo_cnt[l] != 0 && outranks(l, cur_level)) preempt = 1;
      if (preempt && queue_push(cur_level, cur_id)) cur_busy = 0;
    end
    if (!cur_busy) begin
      best = LEVELS;
      for (int l = 0; l < LEVELS; l++)
        if (fifo_cnt[l] != 0 && (best == LEVELS || outranks(l, best))) best = l;
      if (best == LEVELS) begin
        r.idle = 1;
        return r;
      end
      cur_id = lvl_fifo[best][fifo_head[best]];
      fifo_head[best] = (fifo_head[best] + 1) % 16;
      fifo_cnt[best]--;
      cur_level = best[1:0];
      cur_busy = 1;
      slice_count = 0;
    end
    r.run_id = cur_id;
    r.run_level = cur_level;
    r.first_run = !served[cur_id];
    served[cur_id] = 1;
    r.finished = work_left[cur_id] <= 1;
    work_left[cur_id] = r.finished ? 12'd0 : work_left[cur_id] - 12'd1;
    if (slice_count < 255) slice_count++;
    if (r.finished) cur_busy = 0;
    return r;
  endfunction

  // Transaction monitor: prediction, checking and the watchdog.
  always @(posedge clk) begin
    sched_result_t got, want, pred;
    bit moved;
    if (rst_n) begin
      moved = 0;
      if (cfg_valid && cfg_ready) begin
        moved = 1;
        case (cfg_reg_t'(cfg_index))
          REG_SLICE0: slice_len[0] = cfg_data;
          REG_SLICE1: slice_len[1] = cfg_data;
          REG_SLICE2: slice_len[2] = cfg_data;
          REG_RANK0:  level_rank[0] = cfg_data[1:0];
          REG_RANK1:  level_rank[1] = cfg_data[1:0];
          REG_RANK2:  level_rank[2] = cfg_data[1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        moved = 1;
        if (op_t'(in_tuser) == OP_ARRIVE) begin
          sched_arrive(in_tdata[3:0], in_tdata[7:4], in_tdata[19:8]);
        end else begin
          pred = sched_tick();
          pending_results.insert(pending_results.size(), in_typed ? in_typed_res : pred);
        end
      end
      if (out_tvalid && out_tready) begin
        moved = 1;
        results_seen++;
        got = '{idle: out_tuser, run_id: out_tdata[3:0], run_level: out_tdata[5:4],
                first_run: out_tdata[6], finished: out_tdata[7]};
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transaction %p", got);
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (got != want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles > 3000) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // Receiver: changing stall patterns, plus a long hold-off on request.
  bit hold_tog = 0, hold_seen = 0;
  int hold_left = 0, rx_cycle = 0;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (!rst_n) begin
      out_tready <= 0;
    end else if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= 400;
      out_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 0;
    end else begin
      case ((rx_cycle / 64) % 4)
        0, 3: out_tready <= 1;
        1: out_tready <= $urandom_range(0, 1);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  int burst_left = 0;

  task automatic send_item(op_t op, logic [3:0] id, logic [3:0] prio, logic [11:0] burst,
                           bit typed, sched_result_t res);
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {4'b0, burst, prio, id};
    in_typed <= typed;
    in_typed_res <= res;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic send_random(int count, bit flood);
    logic [11:0] burst;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0: burst = 12'($urandom_range(1, 4095));
        1: burst = 12'd4095;
        default: burst = 12'($urandom_range(1, 6));
      endcase
      if (!flood && $urandom_range(0, 99) < 55)
        send_item(OP_TICK, 4'($urandom), 4'($urandom), 12'($urandom), 0, '0);
      else
        send_item(OP_ARRIVE, 4'($urandom_range(0, 15)),
                  flood ? 4'($urandom_range(0, 2)) : 4'($urandom_range(0, 15)), burst, 0, '0);
    end
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [7:0] value);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  stim_row_t directed [$];
  logic [7:0] settings [6][6] = '{
    '{8'd0,   8'd0,   8'd0,   8'd2, 8'd1, 8'd0},
    '{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0},
    '{8'd1,   8'd1,   8'd1,   8'd2, 8'd2, 8'd2},
    '{8'd1,   8'd3,   8'd0,   8'd1, 8'd0, 8'd2},
    '{8'd255, 8'd0,   8'd1,   8'd2, 8'd0, 8'd1},
    '{8'd2,   8'd4,   8'd0,   8'd0, 8'd1, 8'd2}
  };

  function automatic stim_row_t row(op_t op, int id, int prio, int burst,
                                    bit typed = 0, sched_result_t res = '0);
    stim_row_t s;
    s.op = op;
    s.id = 4'(id);
    s.prio = 4'(prio);
    s.burst = 12'(burst);
    s.typed = typed;
    s.res = res;
    return s;
  endfunction

  initial begin
    sched_reset();
    directed = {directed, row(OP_TICK, 0, 0, 0, 1, '{1'b1, 4'd0, 2'd0, 1'b0, 1'b0})};
    directed = {directed, row(OP_ARRIVE, 0, 0, 1)};
    directed = {directed, row(OP_TICK, 0, 0, 0, 1, '{1'b0, 4'd0, 2'd0, 1'b1, 1'b1})};
    directed = {directed, row(OP_ARRIVE, 15, 15, 0)};
    directed = {directed, row(OP_TICK, 15, 15, 4095, 1, '{1'b0, 4'd15, 2'd2, 1'b1, 1'b1})};
    directed = {directed, row(OP_ARRIVE, 7, 3, 4095)};
    directed = {directed, row(OP_ARRIVE, 9, 5, 3)};
    directed = {directed, row(OP_ARRIVE, 4, 2, 3)};
    directed = {directed, row(OP_ARRIVE, 10, 4, 2)};
    directed = {directed, row(OP_ARRIVE, 10, 4, 3)};
    for (int i = 0; i < 6; i++) directed = {directed, row(OP_TICK, 0, 0, 0)};
    directed = {directed, row(OP_ARRIVE, 2, 0, 2)};
    for (int i = 0; i < 8; i++) directed = {directed, row(OP_TICK, 0, 0, 0)};

    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (directed[i])
      send_item(directed[i].op, directed[i].id, directed[i].prio, directed[i].burst,
                directed[i].typed, directed[i].res);
    in_typed <= 0;
    send_random(60, 0);
    drain();
    phases_run++;

    foreach (settings[p]) begin
      for (int r = 0; r < 6; r++) write_reg(cfg_reg_t'(r), settings[p][r]);
      if (p == 2) begin
        send_random(20, 1);
        hold_tog = ~hold_tog;
        send_random(30, 0);
      end
      send_random(70, 0);
      drain();
      phases_run++;
    end

    $display("Ran %0d items over %0d register settings; %0d tick results checked.",
             items_sent, phases_run, results_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_results.size());
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
